/* rtl/core/pyr_pkg.sv */
// ----------------------------------------------------------------------------
// pyr_pkg
// Shared constants, register indexes and helpers for the 3x3 binomial
// half-resolution pyramid reduction block.
// ----------------------------------------------------------------------------
package pyr_pkg;

  // Largest supported source frame
  localparam int unsigned MaxWidth  = 2048;
  localparam int unsigned MaxHeight = 2048;

  // Field widths
  localparam int unsigned PixW = 8;   // source pixel
  localparam int unsigned DimW = 12;  // frame dimension registers
  localparam int unsigned SumW = 12;  // weighted sum in sixteenths

  // Column / row counter widths
  localparam int unsigned ColW = $clog2(MaxWidth);
  localparam int unsigned RowW = $clog2(MaxHeight);

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 1'b1;

  // Register reset values
  localparam logic [DimW-1:0] FrameWidthRst  = 12'd640;
  localparam logic [DimW-1:0] FrameHeightRst = 12'd480;
  localparam logic [DimW-1:0] MinDim         = 12'd2;

  // Clamp a frame dimension to [MinDim, hi]
  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                input logic [DimW-1:0] hi);
    logic [DimW-1:0] r;
    if (v < MinDim) begin
      r = MinDim;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* rtl/core/pyr_ram.sv */
// ----------------------------------------------------------------------------
// pyr_ram
// Generic single-clock RAM: one write port, one read port, registered read
// data that holds while the read enable is low.
// ----------------------------------------------------------------------------
module pyr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/pyramid_reduce_3x3_by_two_unit.sv */
// ----------------------------------------------------------------------------
// pyramid_reduce_3x3_by_two_unit
// Half-resolution reduction of an 8-bit raster image with the 3x3 binomial
// kernel (corners 1, edges 2, center 4); results are exact, in sixteenths.
//
// Usage:
//   s_axis: source pixels in raster order, one per word (tdata[7:0]).
//   m_axis: reduced pixels; tdata[11:0] is the weighted sum, tlast marks the
//   last pixel of an output row, tuser marks the last pixel of the frame.
//   cfg: write frame_width (index 0) or frame_height (index 1) while idle;
//   each write restarts the frame at row 0, column 0. Values are clamped
//   to [2, 2048]. Odd sizes drop the last source row or column.
//   A result is produced when the source pixel at odd row and odd column
//   is accepted; it passes the working stage, then the output register.
//   Throughput is one pixel per clock unless stalled: each pixel does one
//   read and one write of the two-line buffer RAM and one adder tree pass.
//   When the receiver stalls, the result holds in the output register and
//   one more pixel is taken into the working stage; pixels that make no
//   result keep flowing until one that does meets the full output register.
//   Reset: dimensions return to 640 x 480, counters to zero, both stages
//   empty. Line buffer contents need no clearing (border rules mask them).
// ----------------------------------------------------------------------------
module pyramid_reduce_3x3_by_two_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  // Configuration write port
  input  logic                            cfg_we_i,
  input  logic [pyr_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [pyr_pkg::DimW-1:0]        cfg_data_i,

  // Source pixels
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // [7:0] pixel

  // Reduced pixels
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [15:0]                     m_axis_tdata,   // [11:0] filtered_value
  output logic                            m_axis_tlast,   // row_end
  output logic                            m_axis_tuser    // [0] frame_end
);

  localparam int unsigned PixW = pyr_pkg::PixW;
  localparam int unsigned DimW = pyr_pkg::DimW;
  localparam int unsigned SumW = pyr_pkg::SumW;
  localparam int unsigned ColW = pyr_pkg::ColW;
  localparam int unsigned RowW = pyr_pkg::RowW;

  typedef struct packed {
    logic [PixW-1:0] pix;
    logic [ColW-1:0] col;
    logic            first_col;  // window cleared on the left border
    logic            use_mid;    // row above lies inside the frame
    logic            use_top;    // row two above lies inside the frame
    logic            emit;       // odd row, odd column
    logic            row_end;
    logic            frame_end;
  } stage_t;

  typedef struct packed {
    logic [PixW-1:0] top;
    logic [PixW-1:0] mid;
    logic [PixW-1:0] bot;
  } column_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [DimW-1:0] frame_width_q, frame_height_q;
  logic [DimW-1:0] width_eff, height_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= pyr_pkg::FrameWidthRst;
      frame_height_q <= pyr_pkg::FrameHeightRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        pyr_pkg::RegFrameWidth:  frame_width_q  <= cfg_data_i;
        pyr_pkg::RegFrameHeight: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign width_eff  = pyr_pkg::clamp_dim(frame_width_q,  DimW'(pyr_pkg::MaxWidth));
  assign height_eff = pyr_pkg::clamp_dim(frame_height_q, DimW'(pyr_pkg::MaxHeight));

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  logic   s1_valid_q, out_valid_q;
  stage_t s1_q, s1_d;
  logic   in_acc, out_free, s1_adv;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_adv        = s1_valid_q && (!s1_q.emit || out_free);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // --------------------------------------------------------------------------
  // Position counters and per-pixel flags
  // --------------------------------------------------------------------------
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic            last_col, last_row;

  assign last_col = (DimW'(col_q) == width_eff - DimW'(1));
  assign last_row = (DimW'(row_q) == height_eff - DimW'(1));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_we_i) begin
      col_d = '0;
      row_d = '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_comb begin
    s1_d.pix       = s_axis_tdata[PixW-1:0];
    s1_d.col       = col_q;
    s1_d.first_col = (col_q == '0);
    s1_d.use_mid   = (row_q != '0);
    s1_d.use_top   = (row_q > RowW'(1));
    s1_d.emit      = col_q[0] && row_q[0];
    s1_d.row_end   = (DimW'(col_q) == {width_eff[DimW-1:1], 1'b0} - DimW'(1));
    s1_d.frame_end = s1_d.row_end &&
                     (DimW'(row_q) == {height_eff[DimW-1:1], 1'b0} - DimW'(1));
  end

  // Working stage: pixel and its flags, line buffer read in parallel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
  end

  // --------------------------------------------------------------------------
  // Line buffer: [15:8] row two above, [7:0] row one above
  // --------------------------------------------------------------------------
  logic [2*PixW-1:0] line_rdata, line_wdata;

  assign line_wdata = {line_rdata[PixW-1:0], s1_q.pix};

  pyr_ram #(
    .Width (2 * PixW),
    .Depth (pyr_pkg::MaxWidth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_q.col),
    .wdata_i (line_wdata),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (line_rdata)
  );

  // --------------------------------------------------------------------------
  // 3x3 window: current column plus two previous columns
  // --------------------------------------------------------------------------
  column_t cur_col, prev1_q, prev2_q, prev1_eff, prev2_eff;
  logic [SumW-1:0] sum;

  assign cur_col.bot = s1_q.pix;
  assign cur_col.mid = s1_q.use_mid ? line_rdata[PixW-1:0] : '0;
  assign cur_col.top = s1_q.use_top ? line_rdata[2*PixW-1:PixW] : '0;

  // Left border reads as zero
  assign prev1_eff = s1_q.first_col ? '0 : prev1_q;
  assign prev2_eff = s1_q.first_col ? '0 : prev2_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      prev1_q <= cur_col;
      prev2_q <= prev1_eff;
    end
  end

  // Binomial weights 1-2-1 by 1-2-1
  assign sum = SumW'(prev2_eff.top)        + (SumW'(prev2_eff.mid) << 1)
             + SumW'(prev2_eff.bot)        + (SumW'(prev1_eff.top) << 1)
             + (SumW'(prev1_eff.mid) << 2) + (SumW'(prev1_eff.bot) << 1)
             + SumW'(cur_col.top)          + (SumW'(cur_col.mid) << 1)
             + SumW'(cur_col.bot);

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [SumW-1:0] out_sum_q;
  logic            out_last_q, out_user_q;
  logic            out_load;

  assign out_load = s1_adv && s1_q.emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sum_q  <= sum;
      out_last_q <= s1_q.row_end;
      out_user_q <= s1_q.frame_end;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(16 - SumW){1'b0}}, out_sum_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_user_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Column counter never leaves the frame
  a_col_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    DimW'(col_q) < width_eff)
    else $error("column counter outside frame");

  // A configuration write restarts the frame
  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (col_q == '0) && (row_q == '0))
    else $error("counters not cleared by configuration write");

  // The working stage stalls only behind a full, blocked output register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |-> (s1_q.emit && out_valid_q && !m_axis_tready))
    else $error("working stage stalled without cause");

  // A new result comes only from a pixel that completes a window
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && s1_q.emit))
    else $error("result without completed window");

  // Frame end is always also a row end
  a_frame_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("frame end without row end");

endmodule
